/* design/coons_patch_grid_interpolator_unit_defines.svh */
// Assertion macros shared by the Coons grid interpolator RTL.
// No dependencies; the asserting module supplies i_clk and i_rst_n.
`ifndef COONS_PATCH_GRID_INTERPOLATOR_UNIT_DEFINES_SVH
`define COONS_PATCH_GRID_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CPGI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cpgi assertion failed");

// Next-cycle implication, checked out of reset.
`define CPGI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cpgi assertion failed");

`endif

/* design/cpgi_pkg.sv */
// Shared types, codes and tables of the Coons grid interpolator.
// No dependencies.
`default_nettype none
package cpgi_pkg;
    localparam int GRID_MAX   = 64;
    localparam int IDX_W      = 6;
    localparam int CFG_W      = 7;
    localparam int COORD_BITS = 32;
    localparam int WGT_W      = 17;
    localparam int NUM_W      = 23;
    localparam int RECIP_W    = 31;
    localparam int GRID_MIN   = 3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_RANGE  = 1'b1;
    localparam logic REG_COLS  = 1'b0;
    localparam logic REG_ROWS  = 1'b1;

    localparam longint unsigned RecipNum = 64'd2147483648;

    // floor(2^31 / d), used to divide by 2d with a 2^-32 scale
    localparam logic [RECIP_W-1:0] RECIP_TAB [0:63] = '{
        31'd0, 31'd0, 31'(RecipNum / 2), 31'(RecipNum / 3),
        31'(RecipNum / 4), 31'(RecipNum / 5), 31'(RecipNum / 6), 31'(RecipNum / 7),
        31'(RecipNum / 8), 31'(RecipNum / 9), 31'(RecipNum / 10), 31'(RecipNum / 11),
        31'(RecipNum / 12), 31'(RecipNum / 13), 31'(RecipNum / 14), 31'(RecipNum / 15),
        31'(RecipNum / 16), 31'(RecipNum / 17), 31'(RecipNum / 18), 31'(RecipNum / 19),
        31'(RecipNum / 20), 31'(RecipNum / 21), 31'(RecipNum / 22), 31'(RecipNum / 23),
        31'(RecipNum / 24), 31'(RecipNum / 25), 31'(RecipNum / 26), 31'(RecipNum / 27),
        31'(RecipNum / 28), 31'(RecipNum / 29), 31'(RecipNum / 30), 31'(RecipNum / 31),
        31'(RecipNum / 32), 31'(RecipNum / 33), 31'(RecipNum / 34), 31'(RecipNum / 35),
        31'(RecipNum / 36), 31'(RecipNum / 37), 31'(RecipNum / 38), 31'(RecipNum / 39),
        31'(RecipNum / 40), 31'(RecipNum / 41), 31'(RecipNum / 42), 31'(RecipNum / 43),
        31'(RecipNum / 44), 31'(RecipNum / 45), 31'(RecipNum / 46), 31'(RecipNum / 47),
        31'(RecipNum / 48), 31'(RecipNum / 49), 31'(RecipNum / 50), 31'(RecipNum / 51),
        31'(RecipNum / 52), 31'(RecipNum / 53), 31'(RecipNum / 54), 31'(RecipNum / 55),
        31'(RecipNum / 56), 31'(RecipNum / 57), 31'(RecipNum / 58), 31'(RecipNum / 59),
        31'(RecipNum / 60), 31'(RecipNum / 61), 31'(RecipNum / 62), 31'(RecipNum / 63)
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_pt;

    // 0 bottom, 1 top, 2 left, 3 right, 4 C00, 5 C11, 6 C10, 7 C01
    typedef t_pt [7:0] t_pts;
endpackage
`default_nettype wire

/* design/cpgi_ram.sv */
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`default_nettype none
module cpgi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* design/cpgi_wdiv.sv */
// Two-stage rounded weight divider: q = floor(num / 2d) by reciprocal.
// Depends on cpgi_pkg for widths.
`default_nettype none
module cpgi_wdiv
    import cpgi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [IDX_W-1:0]   i_den,
    input  wire logic [RECIP_W-1:0] i_recip,
    output logic      [WGT_W-1:0]   o_q
);
    logic [NUM_W+RECIP_W-1:0] n_prod;
    logic [WGT_W-1:0]         r_qe;
    logic [NUM_W-1:0]         r_num;
    logic [IDX_W-1:0]         r_den;
    logic [NUM_W-1:0]         n_rem;
    logic                     n_up;

    assign n_prod = (NUM_W+RECIP_W)'(i_num) * (NUM_W+RECIP_W)'(i_recip);

    // estimate is low by at most one; fix with one compare
    assign n_rem = r_num - (NUM_W'(r_qe) * NUM_W'({r_den, 1'b0}));
    assign n_up  = n_rem >= NUM_W'({r_den, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qe  <= n_prod[32 +: WGT_W];
            r_num <= i_num;
            r_den <= i_den;
            o_q   <= r_qe + WGT_W'(n_up);
        end
    end
endmodule
`default_nettype wire

/* design/coons_patch_grid_interpolator_unit.sv */
// Top level of the Coons patch grid interpolator: edge stores and blend pipeline.
// Depends on cpgi_pkg, cpgi_ram, cpgi_wdiv and the assertion macro header.
//
//  channel   | handshake             | word
//  ----------+-----------------------+----------------------------------------
//  input     | i_valid / o_ready     | i_action, i_col_index, i_row_index,
//            |                       | i_x_in, i_y_in
//  result    | o_valid / i_ready     | o_x_out, o_y_out, o_status
//  config    | i_cfg_we              | i_cfg_index, i_cfg_data
//
// One word enters per cycle while o_ready is high. Each accepted query gives one
// result; a write gives no result and takes effect at acceptance.
// The depth is set by the reciprocal weight divider, the weight
// product stage, the coordinate multiplier stage and the sum stage.
// Reset clears the valid bits and the grid size registers (64 x 64); edge
// stores are not cleared. A stall on the result side freezes every stage.
`default_nettype none
`include "coons_patch_grid_interpolator_unit_defines.svh"
module coons_patch_grid_interpolator_unit
    import cpgi_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_action,
    input  wire logic [IDX_W-1:0]             i_col_index,
    input  wire logic [IDX_W-1:0]             i_row_index,
    input  wire logic signed [COORD_BITS-1:0] i_x_in,
    input  wire logic signed [COORD_BITS-1:0] i_y_in,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [COORD_BITS-1:0]      o_x_out,
    output logic signed [COORD_BITS-1:0]      o_y_out,
    output logic                              o_status,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [CFG_W-1:0]             i_cfg_data
);
    localparam int PT_W = 2 * COORD_BITS;
    localparam int EP_W = WGT_W + COORD_BITS + 1;
    localparam int CP_W = 2 * WGT_W + COORD_BITS;
    localparam int AC_W = CP_W + 2;

    // grid size registers
    logic [CFG_W-1:0] r_cols, r_rows;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
        if (v < CFG_W'(GRID_MIN)) begin
            return CFG_W'(GRID_MIN);
        end else if (v > CFG_W'(GRID_MAX)) begin
            return CFG_W'(GRID_MAX);
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_W'(GRID_MAX);
            r_rows <= CFG_W'(GRID_MAX);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_COLS) begin
                r_cols <= clamp_size(i_cfg_data);
            end else begin
                r_rows <= clamp_size(i_cfg_data);
            end
        end
    end

    // one global advance: every stage moves when the result register frees up
    logic en, acc;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;

    logic [IDX_W-1:0] cl, rl;
    logic             in_rng, wr, we_b, we_t, we_l, we_r;
    logic [PT_W-1:0]  wdata;

    assign cl     = IDX_W'(r_cols - 1'b1);
    assign rl     = IDX_W'(r_rows - 1'b1);
    assign in_rng = (CFG_W'(i_col_index) < r_cols) && (CFG_W'(i_row_index) < r_rows);
    assign wr     = acc && (i_action == ACT_WRITE) && in_rng;
    assign we_b   = wr && (i_row_index == '0);
    assign we_t   = wr && (i_row_index == rl);
    assign we_l   = wr && (i_col_index == '0);
    assign we_r   = wr && (i_col_index == cl);
    assign wdata  = {i_x_in, i_y_in};

    // bottom and top are kept twice: one copy reads at the column, one at
    // the last column for the right-hand corners
    logic [PT_W-1:0] rd_ba, rd_bb, rd_ta, rd_tb, rd_l, rd_r;

    cpgi_ram #(.WIDTH(PT_W), .DEPTH(GRID_MAX)) u_ram_ba (
        .i_clk, .i_we(we_b), .i_waddr(i_col_index), .i_wdata(wdata),
        .i_re(acc), .i_raddr(i_col_index), .o_rdata(rd_ba));
    cpgi_ram #(.WIDTH(PT_W), .DEPTH(GRID_MAX)) u_ram_bb (
        .i_clk, .i_we(we_b), .i_waddr(i_col_index), .i_wdata(wdata),
        .i_re(acc), .i_raddr(cl), .o_rdata(rd_bb));
    cpgi_ram #(.WIDTH(PT_W), .DEPTH(GRID_MAX)) u_ram_ta (
        .i_clk, .i_we(we_t), .i_waddr(i_col_index), .i_wdata(wdata),
        .i_re(acc), .i_raddr(i_col_index), .o_rdata(rd_ta));
    cpgi_ram #(.WIDTH(PT_W), .DEPTH(GRID_MAX)) u_ram_tb (
        .i_clk, .i_we(we_t), .i_waddr(i_col_index), .i_wdata(wdata),
        .i_re(acc), .i_raddr(cl), .o_rdata(rd_tb));
    cpgi_ram #(.WIDTH(PT_W), .DEPTH(GRID_MAX)) u_ram_l (
        .i_clk, .i_we(we_l), .i_waddr(i_row_index), .i_wdata(wdata),
        .i_re(acc), .i_raddr(i_row_index), .o_rdata(rd_l));
    cpgi_ram #(.WIDTH(PT_W), .DEPTH(GRID_MAX)) u_ram_r (
        .i_clk, .i_we(we_r), .i_waddr(i_row_index), .i_wdata(wdata),
        .i_re(acc), .i_raddr(i_row_index), .o_rdata(rd_r));

    // column-zero corners live in plain registers
    t_pt r_c00, r_c01;
    always_ff @(posedge i_clk) begin
        if (we_b && (i_col_index == '0)) begin
            r_c00 <= wdata;
        end
        if (we_t && (i_col_index == '0)) begin
            r_c01 <= wdata;
        end
    end

    // stage 1: weight numerators and reciprocals
    logic                  r1_vld, r1_st;
    logic [NUM_W-1:0]      r1_nu, r1_nv;
    logic [IDX_W-1:0]      r1_du, r1_dv;
    logic [RECIP_W-1:0]    r1_ru, r1_rv;
    t_pt                   r1_c00, r1_c01;
    t_pts                  s1_pts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid && (i_action == ACT_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_st  <= in_rng ? ST_OK : ST_RANGE;
            r1_nu  <= {i_col_index, 17'd0} + NUM_W'(cl);
            r1_nv  <= {i_row_index, 17'd0} + NUM_W'(rl);
            r1_du  <= cl;
            r1_dv  <= rl;
            r1_ru  <= RECIP_TAB[cl];
            r1_rv  <= RECIP_TAB[rl];
            r1_c00 <= r_c00;
            r1_c01 <= r_c01;
        end
    end

    assign s1_pts = {r1_c01, rd_bb, rd_tb, r1_c00, rd_r, rd_l, rd_ta, rd_ba};

    // stages 2 and 3: weights u and v
    logic [WGT_W-1:0] s3_u, s3_v;

    cpgi_wdiv u_div_u (.i_clk, .i_en(en), .i_num(r1_nu), .i_den(r1_du),
        .i_recip(r1_ru), .o_q(s3_u));
    cpgi_wdiv u_div_v (.i_clk, .i_en(en), .i_num(r1_nv), .i_den(r1_dv),
        .i_recip(r1_rv), .o_q(s3_v));

    logic r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic r2_st, r3_st, r4_st, r5_st, r6_st;
    t_pts r2_pts, r3_pts, r4_pts;

    // stage 4: complements and corner weight products
    logic [WGT_W-1:0]   r4_u, r4_v, r4_u1, r4_v1;
    logic [2*WGT_W-2:0] r4_p00, r4_p11, r4_p10, r4_p01;
    logic [WGT_W-1:0]   n_u1, n_v1;

    assign n_u1 = WGT_W'(17'd65536) - s3_u;
    assign n_v1 = WGT_W'(17'd65536) - s3_v;

    // stage 5: coordinate products
    logic signed [EP_W-1:0] r5_ex [4], r5_ey [4];
    logic signed [CP_W-1:0] r5_cx [4], r5_cy [4];

    function automatic logic signed [EP_W-1:0] mul_e(input logic [WGT_W-1:0] w,
                                                     input logic signed [COORD_BITS-1:0] c);
        logic signed [WGT_W:0] ws;
        ws = {1'b0, w};
        return EP_W'(ws) * EP_W'(c);
    endfunction

    function automatic logic signed [CP_W-1:0] mul_c(input logic [2*WGT_W-2:0] w,
                                                     input logic signed [COORD_BITS-1:0] c);
        logic signed [2*WGT_W-1:0] ws;
        ws = {1'b0, w};
        return CP_W'(ws) * CP_W'(c);
    endfunction

    // stage 6: exact sums with round bias
    logic signed [AC_W-1:0] r6_ax, r6_ay;

    function automatic logic signed [AC_W-1:0] blend_sum(
        input logic signed [EP_W-1:0] e [4], input logic signed [CP_W-1:0] c [4]);
        logic signed [AC_W-1:0] se, sc;
        se = AC_W'(e[0]) + AC_W'(e[1]) + AC_W'(e[2]) + AC_W'(e[3]);
        sc = AC_W'(c[0]) + AC_W'(c[1]) + AC_W'(c[2]) + AC_W'(c[3]);
        return (se <<< 16) - sc + AC_W'(64'sd2147483648);
    endfunction

    // floor by 2^32, then clip to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] round_sat(
        input logic signed [AC_W-1:0] a);
        logic signed [AC_W-33:0] sh;
        sh = a[AC_W-1:32];
        if (sh > (AC_W-32)'(64'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (sh < -(AC_W-32)'(64'sh80000000)) begin
            return 32'sh80000000;
        end
        return sh[COORD_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            o_valid <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_st  <= r1_st;
            r2_pts <= s1_pts;
            r3_st  <= r2_st;
            r3_pts <= r2_pts;

            r4_st  <= r3_st;
            r4_pts <= r3_pts;
            r4_u   <= s3_u;
            r4_v   <= s3_v;
            r4_u1  <= n_u1;
            r4_v1  <= n_v1;
            r4_p00 <= (2*WGT_W-1)'(n_u1) * (2*WGT_W-1)'(n_v1);
            r4_p11 <= (2*WGT_W-1)'(s3_u) * (2*WGT_W-1)'(s3_v);
            r4_p10 <= (2*WGT_W-1)'(s3_u) * (2*WGT_W-1)'(n_v1);
            r4_p01 <= (2*WGT_W-1)'(n_u1) * (2*WGT_W-1)'(s3_v);

            r5_st    <= r4_st;
            r5_ex[0] <= mul_e(r4_v1, r4_pts[0].x);
            r5_ex[1] <= mul_e(r4_v,  r4_pts[1].x);
            r5_ex[2] <= mul_e(r4_u1, r4_pts[2].x);
            r5_ex[3] <= mul_e(r4_u,  r4_pts[3].x);
            r5_ey[0] <= mul_e(r4_v1, r4_pts[0].y);
            r5_ey[1] <= mul_e(r4_v,  r4_pts[1].y);
            r5_ey[2] <= mul_e(r4_u1, r4_pts[2].y);
            r5_ey[3] <= mul_e(r4_u,  r4_pts[3].y);
            r5_cx[0] <= mul_c(r4_p00, r4_pts[4].x);
            r5_cx[1] <= mul_c(r4_p11, r4_pts[5].x);
            r5_cx[2] <= mul_c(r4_p10, r4_pts[6].x);
            r5_cx[3] <= mul_c(r4_p01, r4_pts[7].x);
            r5_cy[0] <= mul_c(r4_p00, r4_pts[4].y);
            r5_cy[1] <= mul_c(r4_p11, r4_pts[5].y);
            r5_cy[2] <= mul_c(r4_p10, r4_pts[6].y);
            r5_cy[3] <= mul_c(r4_p01, r4_pts[7].y);

            r6_st <= r5_st;
            r6_ax <= blend_sum(r5_ex, r5_cx);
            r6_ay <= blend_sum(r5_ey, r5_cy);

            // drop the blend for positions off the grid
            o_status <= r6_st;
            o_x_out  <= (r6_st == ST_RANGE) ? '0 : round_sat(r6_ax);
            o_y_out  <= (r6_st == ST_RANGE) ? '0 : round_sat(r6_ay);
        end
    end

    `CPGI_ASSERT_IMP(a_range_zero, o_valid && (o_status == ST_RANGE), (o_x_out == '0) && (o_y_out == '0))
    `CPGI_ASSERT_IMP(a_cols_ok, 1'b1, (r_cols >= CFG_W'(GRID_MIN)) && (r_cols <= CFG_W'(GRID_MAX)))
    `CPGI_ASSERT_IMP(a_rows_ok, 1'b1, (r_rows >= CFG_W'(GRID_MIN)) && (r_rows <= CFG_W'(GRID_MAX)))
    `CPGI_ASSERT_NXT(a_query_enters, acc && (i_action == ACT_QUERY), r1_vld)
    `CPGI_ASSERT_NXT(a_write_silent, acc && (i_action == ACT_WRITE), !r1_vld)
endmodule
`default_nettype wire

/* bench/tb_coons_patch_grid_interpolator_unit.sv */
// Self-checking bench for the Coons patch grid interpolator: boundary writes, blended queries.
// Depends on cpgi_pkg and coons_patch_grid_interpolator_unit; predicts each result internally.
`timescale 1ns / 1ps
`default_nettype none
module tb_coons_patch_grid_interpolator_unit;
    import cpgi_pkg::*;

    localparam int IDLE_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_WAIT = 12;     // extra wait after the last expected result

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic                         act;
        logic [IDX_W-1:0]             col;
        logic [IDX_W-1:0]             row;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_grid_word;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         status;
    } t_blend_word;

    // Mirror of the edge stores and grid size; computes the blended point of each query.
    class coons_scoreboard;
        int          cols;
        int          rows;
        t_pt         bottom [GRID_MAX];
        t_pt         top    [GRID_MAX];
        t_pt         left   [GRID_MAX];
        t_pt         right  [GRID_MAX];
        t_blend_word due_points [$];

        function new();
            cols = GRID_MAX;
            rows = GRID_MAX;
        endfunction

        function void set_size(logic idx, logic [CFG_W-1:0] d);
            int n;
            n = d;
            if (n < GRID_MIN) n = GRID_MIN;
            if (n > GRID_MAX) n = GRID_MAX;
            if (idx == REG_COLS) cols = n;
            else rows = n;
        endfunction

        function int pending();
            return due_points.size();
        endfunction

        // Blend one coordinate axis; weights u, v are Q1.16.
        function logic signed [COORD_BITS-1:0] mix(
            logic signed [COORD_BITS-1:0] b, logic signed [COORD_BITS-1:0] t,
            logic signed [COORD_BITS-1:0] l, logic signed [COORD_BITS-1:0] r,
            logic signed [COORD_BITS-1:0] c00, logic signed [COORD_BITS-1:0] c11,
            logic signed [COORD_BITS-1:0] c10, logic signed [COORD_BITS-1:0] c01,
            longint u, longint v);
            longint one;
            t_wide  acc;
            t_wide  q;
            one = 65536;
            acc = t_wide'(b) * t_wide'((one - v) * one) + t_wide'(t) * t_wide'(v * one)
                + t_wide'(l) * t_wide'((one - u) * one) + t_wide'(r) * t_wide'(u * one)
                - t_wide'(c00) * t_wide'((one - u) * (one - v))
                - t_wide'(c11) * t_wide'(u * v)
                - t_wide'(c10) * t_wide'(u * (one - v))
                - t_wide'(c01) * t_wide'((one - u) * v)
                + (t_wide'(1) <<< 31);
            q = acc >>> 32;
            if (q > t_wide'(32'sh7fff_ffff)) q = t_wide'(32'sh7fff_ffff);
            if (q < t_wide'(32'sh8000_0000)) q = t_wide'(32'sh8000_0000);
            return q[COORD_BITS-1:0];
        endfunction

        function void note_word(t_grid_word w);
            int          c;
            int          r;
            int          cl;
            longint      u;
            longint      v;
            t_pt         p;
            t_blend_word e;
            c  = w.col;
            r  = w.row;
            cl = cols - 1;
            p.x = w.x;
            p.y = w.y;
            if (w.act == ACT_WRITE) begin
                if (c >= cols || r >= rows) return;
                if (r == 0) bottom[c] = p;
                if (r == rows - 1) top[c] = p;
                if (c == 0) left[r] = p;
                if (c == cols - 1) right[r] = p;
                return;
            end
            if (c >= cols || r >= rows) begin
                e.x = '0;
                e.y = '0;
                e.status = ST_RANGE;
            end else begin
                u = (longint'(c) * 131072 + (cols - 1)) / (2 * (cols - 1));
                v = (longint'(r) * 131072 + (rows - 1)) / (2 * (rows - 1));
                e.x = mix(bottom[c].x, top[c].x, left[r].x, right[r].x,
                          bottom[0].x, top[cl].x, bottom[cl].x, top[0].x, u, v);
                e.y = mix(bottom[c].y, top[c].y, left[r].y, right[r].y,
                          bottom[0].y, top[cl].y, bottom[cl].y, top[0].y, u, v);
                e.status = ST_OK;
            end
            due_points = {due_points, e};
        endfunction

        // Compare against the oldest expectation; return the number of wrong fields.
        function int check_result(t_blend_word got, output string msg);
            t_blend_word e;
            int          bad;
            bad = 0;
            msg = "";
            if (due_points.size() == 0) begin
                msg = "result word with no query outstanding";
                return 1;
            end
            e = due_points.pop_front();
            if (got.status !== e.status) bad++;
            if (got.x !== e.x) bad++;
            if (got.y !== e.y) bad++;
            if (bad != 0)
                msg = $sformatf("mismatch: got x=%h y=%h st=%b, want x=%h y=%h st=%b",
                                got.x, got.y, got.status, e.x, e.y, e.status);
            return bad;
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_action;
    logic [IDX_W-1:0]             i_col_index;
    logic [IDX_W-1:0]             i_row_index;
    logic signed [COORD_BITS-1:0] i_x_in;
    logic signed [COORD_BITS-1:0] i_y_in;
    logic                         o_valid;
    logic                         i_ready;
    logic signed [COORD_BITS-1:0] o_x_out;
    logic signed [COORD_BITS-1:0] o_y_out;
    logic                         o_status;
    logic                         i_cfg_we;
    logic                         i_cfg_index;
    logic [CFG_W-1:0]             i_cfg_data;

    coons_patch_grid_interpolator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_col_index (i_col_index),
        .i_row_index (i_row_index),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    coons_scoreboard sb;
    int              errors;
    int              idle_cycles;
    bit              steady;        // no idling on either side while set
    bit              out_started;

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report(string msg);
        $display("[%0t] %s", $realtime, msg);
        errors++;
    endtask

    // Draw a coordinate: full range, near zero or one of the extremes.
    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return $urandom;
        if (k < 8) return $signed(32'($urandom_range(0, 262143))) - 131072;
        if (k == 8) return 32'sh7fff_ffff;
        return 32'sh8000_0000;
    endfunction

    // Present one word, hold it until accepted, then log it with the scoreboard.
    task automatic send_word(t_grid_word w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= w.act;
        i_col_index <= w.col;
        i_row_index <= w.row;
        i_x_in      <= w.x;
        i_y_in      <= w.y;
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(w);
    endtask

    task automatic send_fields(logic act, int c, int r,
                               logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y);
        t_grid_word w;
        w.act = act;
        w.col = c[IDX_W-1:0];
        w.row = r[IDX_W-1:0];
        w.x   = x;
        w.y   = y;
        send_word(w);
    endtask

    // Drop valid right at the last acceptance and wait until the pipe is empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_size(idx, d);
        @(posedge i_clk);
    endtask

    // Write every boundary point of the grid in use, in shuffled order.
    task automatic fill_boundary();
        int spots [$];
        int j;
        int k;
        int t;
        for (int c = 0; c < sb.cols; c++)
            for (int r = 0; r < sb.rows; r++)
                if (c == 0 || r == 0 || c == sb.cols - 1 || r == sb.rows - 1)
                    spots = {spots, c * 64 + r};
        for (j = spots.size() - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            t = spots[j];
            spots[j] = spots[k];
            spots[k] = t;
        end
        foreach (spots[i])
            send_fields(ACT_WRITE, spots[i] / 64, spots[i] % 64, pick_coord(), pick_coord());
    endtask

    // Mostly in-grid queries and boundary rewrites, with some stray words.
    task automatic random_words(int n);
        int k;
        int c;
        int r;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            c = $urandom_range(0, sb.cols - 1);
            r = $urandom_range(0, sb.rows - 1);
            if (k < 45) begin
                send_fields(ACT_QUERY, c, r, $urandom, $urandom);
            end else if (k < 55) begin
                send_fields(ACT_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom, $urandom);
            end else if (k < 85) begin
                case ($urandom_range(0, 3))
                    0: r = 0;
                    1: r = sb.rows - 1;
                    2: c = 0;
                    default: c = sb.cols - 1;
                endcase
                send_fields(ACT_WRITE, c, r, pick_coord(), pick_coord());
            end else begin
                send_fields(ACT_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                            pick_coord(), pick_coord());
            end
        end
    endtask

    // Result side: stall at random, check each accepted word.
    initial begin
        t_blend_word got;
        string       msg;
        int          gap;
        i_ready = 1'b0;
        wait (out_started);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.x      = o_x_out;
            got.y      = o_y_out;
            got.status = o_status;
            if (sb.check_result(got, msg) != 0) report(msg);
        end
    end

    // Watchdog: end the run when no word moves for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] setting [0:7][0:1];
        sb          = new();
        errors      = 0;
        steady      = 1'b0;
        out_started = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_action    = ACT_WRITE;
        i_col_index = '0;
        i_row_index = '0;
        i_x_in      = '0;
        i_y_in      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_COLS;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        out_started = 1'b1;
        @(posedge i_clk);

        // Directed: 3 x 3 grid via clamped low values, corners at the negative x and
        // positive y extremes, edge midpoints the other way round, so the center saturates.
        write_reg(REG_COLS, 7'd0);
        write_reg(REG_ROWS, 7'd2);
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                if (c != 1 || r != 1) begin
                    if (c != 1 && r != 1)
                        send_fields(ACT_WRITE, c, r, 32'sh8000_0000, 32'sh7fff_ffff);
                    else
                        send_fields(ACT_WRITE, c, r, 32'sh7fff_ffff, 32'sh8000_0000);
                end
        send_fields(ACT_WRITE, 1, 1, 32'sh1234_5678, -32'sd1);    // interior, ignored
        send_fields(ACT_WRITE, 5, 2, 32'sh0000_0001, 32'sh0000_0001);  // outside, ignored
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                send_fields(ACT_QUERY, c, r, '0, '0);
        send_fields(ACT_QUERY, 63, 63, 32'shffff_ffff, 32'shffff_ffff);
        send_fields(ACT_QUERY, 3, 0, '0, '0);
        send_fields(ACT_QUERY, 0, 3, '0, '0);
        drain();

        // Phases: clamped high values, skewed extremes, then random sizes.
        setting[0] = '{7'd127, 7'd65};
        setting[1] = '{7'd3, 7'd64};
        setting[2] = '{7'd64, 7'd3};
        setting[3] = '{7'd1, 7'd100};
        for (int p = 4; p < 8; p++)
            setting[p] = '{7'($urandom_range(3, 20)), 7'($urandom_range(0, 24))};
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_COLS, setting[p][0]);
            write_reg(REG_ROWS, setting[p][1]);
            steady = ($urandom_range(0, 3) == 0);
            fill_boundary();
            random_words(35);
            steady = 1'b0;
            random_words(12);
            drain();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
